### rtl/knap_pkg.sv
// ----------------------------------------------------------------------------
// knap_pkg
// Shared types and constants for the 0/1 knapsack dynamic-programming solver.
// ----------------------------------------------------------------------------
package knap_pkg;

    localparam int MAX_CAPACITY = 1023;
    localparam int ROW_DEPTH    = MAX_CAPACITY + 1;
    localparam int IDX_W        = $clog2(ROW_DEPTH);

    localparam int WEIGHT_W = 10;
    localparam int VALUE_W  = 16;
    localparam int CAP_W    = 10;
    localparam int BEST_W   = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(1023);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic               last;
        logic               skip;
        logic [IDX_W-1:0]   weight;
        logic [VALUE_W-1:0] value;
        logic [IDX_W-1:0]   cap;
    } cmd_t;

    typedef struct packed {
        logic init_done;
    } back_stat_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_FETCH,
        ST_WAIT,
        ST_CLEAR
    } back_state_t;

endpackage

### rtl/knap_front.sv
// ----------------------------------------------------------------------------
// knap_front
// Takes requests and capacity writes, classifies each request into a command.
// ----------------------------------------------------------------------------
module knap_front (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [knap_pkg::CAP_W-1:0]      cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [knap_pkg::WEIGHT_W-1:0]   s_item_weight,
    input  logic [knap_pkg::VALUE_W-1:0]    s_item_value,
    input  logic                            s_last_item,
    input  knap_pkg::back_stat_t            back_stat,
    input  logic                            q_full,
    output logic                            q_push,
    output knap_pkg::cmd_t                  q_cmd
);
    import knap_pkg::*;

    logic [CAP_W-1:0] capacity_reg;
    logic [CAP_W-1:0] capacity_next;
    logic             heavy;

    always_comb begin
        capacity_next = cfg_wr_en ? cfg_wr_data : capacity_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg <= CAP_RESET;
        end else begin
            capacity_reg <= capacity_next;
        end
    end

    assign heavy   = 32'(s_item_weight) > 32'(MAX_CAPACITY);
    assign s_ready = back_stat.init_done && !q_full;
    assign q_push  = s_valid && s_ready;

    always_comb begin
        q_cmd.last   = s_last_item;
        q_cmd.skip   = heavy;
        q_cmd.weight = IDX_W'(s_item_weight);
        q_cmd.value  = s_item_value;
        if (32'(capacity_reg) > 32'(MAX_CAPACITY)) begin
            q_cmd.cap = IDX_W'(MAX_CAPACITY);
        end else begin
            q_cmd.cap = IDX_W'(capacity_reg);
        end
    end

endmodule

### rtl/knap_queue.sv
// ----------------------------------------------------------------------------
// knap_queue
// Short command queue between the front and back ends.
// ----------------------------------------------------------------------------
module knap_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  knap_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           pop_valid,
    output knap_pkg::cmd_t pop_data
);
    import knap_pkg::*;

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign full      = count_reg == QCNT_W'(QUEUE_DEPTH);
    assign pop_valid = count_reg != '0;
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

### rtl/knap_back.sv
// ----------------------------------------------------------------------------
// knap_back
// Sweep engine: best-value row memory, downward read-modify-write sweep,
// result fetch, row clearing and the result register.
// ----------------------------------------------------------------------------
module knap_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    input  knap_pkg::cmd_t                q_data,
    output logic                          q_pop,
    output knap_pkg::back_stat_t          back_stat,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [knap_pkg::BEST_W-1:0]   m_best_value
);
    import knap_pkg::*;

    back_state_t       state_reg;
    back_state_t       state_next;
    cmd_t              cur_reg;
    cmd_t              cur_next;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [IDX_W-1:0]  s1_idx_reg;
    logic [IDX_W-1:0]  s1_idx_next;
    logic              init_done_reg;
    logic              init_done_next;
    logic              m_valid_reg;
    logic              m_valid_next;
    logic [BEST_W-1:0] best_value_reg;
    logic [BEST_W-1:0] best_value_next;

    logic [BEST_W-1:0] row_mem [ROW_DEPTH];
    logic [BEST_W-1:0] rd_a_reg;
    logic [BEST_W-1:0] rd_b_reg;

    logic              re;
    logic [IDX_W-1:0]  raddr_a;
    logic [IDX_W-1:0]  raddr_b;
    logic              clr_we;
    logic              load_out;
    logic              out_free;
    logic              sweep_end;
    logic [BEST_W:0]   sum;
    logic [BEST_W-1:0] cand;
    logic              sw_we;
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [BEST_W-1:0] wdata;

    assign out_free  = !m_valid_reg || m_ready;
    assign sweep_end = idx_reg == cur_reg.weight;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    if (!q_data.skip) begin
                        state_next = ST_SWEEP;
                    end else if (q_data.last) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_SWEEP: begin
                if (sweep_end) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = cur_reg.last ? ST_FETCH : ST_IDLE;
            end
            ST_FETCH: begin
                state_next = ST_WAIT;
            end
            ST_WAIT: begin
                if (out_free) begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR: begin
                if (idx_reg == '0) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb begin
        q_pop          = 1'b0;
        cur_next       = cur_reg;
        idx_next       = idx_reg;
        re             = 1'b0;
        raddr_a        = idx_reg;
        raddr_b        = idx_reg - cur_reg.weight;
        clr_we         = 1'b0;
        load_out       = 1'b0;
        s1_valid_next  = 1'b0;
        s1_idx_next    = idx_reg;
        init_done_next = init_done_reg;
        case (state_reg)
            ST_IDLE: begin
                q_pop = q_valid;
                if (q_valid) begin
                    cur_next = q_data;
                    idx_next = IDX_W'(MAX_CAPACITY);
                end
            end
            ST_SWEEP: begin
                re            = 1'b1;
                s1_valid_next = 1'b1;
                if (!sweep_end) begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            ST_DRAIN: begin
                idx_next = idx_reg;
            end
            ST_FETCH: begin
                re      = 1'b1;
                raddr_a = cur_reg.cap;
            end
            ST_WAIT: begin
                load_out = out_free;
                if (out_free) begin
                    idx_next = IDX_W'(MAX_CAPACITY);
                end
            end
            ST_CLEAR: begin
                clr_we = 1'b1;
                if (idx_reg == '0) begin
                    init_done_next = 1'b1;
                end else begin
                    idx_next = idx_reg - IDX_W'(1);
                end
            end
            default: begin
                q_pop = 1'b0;
            end
        endcase
    end

    // saturating candidate and write port
    always_comb begin
        sum   = {1'b0, rd_b_reg} + (BEST_W + 1)'(cur_reg.value);
        cand  = sum[BEST_W] ? '1 : sum[BEST_W-1:0];
        sw_we = s1_valid_reg && (cand > rd_a_reg);
        we    = clr_we || sw_we;
        waddr = clr_we ? idx_reg : s1_idx_reg;
        wdata = clr_we ? '0 : cand;
    end

    always_comb begin
        best_value_next = load_out ? rd_a_reg : best_value_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            idx_reg       <= IDX_W'(MAX_CAPACITY);
            s1_valid_reg  <= 1'b0;
            init_done_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            s1_valid_reg  <= s1_valid_next;
            init_done_reg <= init_done_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg        <= cur_next;
        s1_idx_reg     <= s1_idx_next;
        best_value_reg <= best_value_next;
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            row_mem[waddr] <= wdata;
        end
        if (re) begin
            rd_a_reg <= row_mem[raddr_a];
            rd_b_reg <= row_mem[raddr_b];
        end
    end

    assign back_stat.init_done = init_done_reg;
    assign m_valid             = m_valid_reg;
    assign m_best_value        = best_value_reg;

endmodule

### rtl/zero_one_knapsack_dp_top.sv
// ----------------------------------------------------------------------------
// zero_one_knapsack_dp_top
// 0/1 knapsack solver: front end, command queue and row sweep engine.
//
//   channel   direction  handshake             payload
//   s_*       in         s_valid / s_ready     item_weight, item_value, last_item
//   m_*       out        m_valid / m_ready     best_value
//   cfg_*     in         cfg_wr_en             capacity
//
// An item of weight w sweeps the row from MAX_CAPACITY down to w, one
// read-modify-write per cycle on the dual-read row memory, between an issue
// step and a drain step. A last item adds a result fetch and a row clear.
// After reset a clearing pass runs with s_ready low.
// The queue holds two requests, so the input can still take up to two items
// while the sweep runs or a result waits on m_ready.
// ----------------------------------------------------------------------------
module zero_one_knapsack_dp_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [knap_pkg::CAP_W-1:0]    cfg_wr_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [knap_pkg::WEIGHT_W-1:0] s_item_weight,
    input  logic [knap_pkg::VALUE_W-1:0]  s_item_value,
    input  logic                          s_last_item,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [knap_pkg::BEST_W-1:0]   m_best_value
);
    import knap_pkg::*;

    back_stat_t back_stat;
    logic       q_full;
    logic       q_push;
    cmd_t       q_cmd;
    logic       q_pop;
    logic       q_valid;
    cmd_t       q_data;

    knap_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item_weight (s_item_weight),
        .s_item_value  (s_item_value),
        .s_last_item   (s_last_item),
        .back_stat     (back_stat),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_cmd         (q_cmd)
    );

    knap_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    knap_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .q_pop        (q_pop),
        .back_stat    (back_stat),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_best_value (m_best_value)
    );

endmodule

### rtl/knap_checker.sv
// ----------------------------------------------------------------------------
// knap_checker
// Port-level checks on the knapsack solver, bound to the top level.
// ----------------------------------------------------------------------------
module knap_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [knap_pkg::BEST_W-1:0] m_best_value
);
    import knap_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_best_value))
        else $error("result changed while stalled");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("activity during row clearing after reset");

    a_ctrl_known: assert property (@(posedge aclk) disable iff (!aresetn)
        !$isunknown(m_valid) && !$isunknown(s_ready))
        else $error("unknown handshake output");

    a_accept_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |-> !$isunknown(s_valid))
        else $error("unknown request handshake");

endmodule

bind zero_one_knapsack_dp_top knap_checker u_checker (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 0/1 knapsack solver. Item sets go in through
// the request channel; each last item yields one best value, checked against
// its table value, if any, or a row-based predictor in the bench. A short
// table of hand-picked sets comes first, then random sets under several
// capacity settings, with idle bursts on both channels and a quiet tail.
// ----------------------------------------------------------------------------
module tb;
    import knap_pkg::*;

    typedef struct packed {
        logic                cap_wr;
        logic [CAP_W-1:0]    cap;
        logic [WEIGHT_W-1:0] weight;
        logic [VALUE_W-1:0]  value;
        logic                last;
        logic                known;
        logic [BEST_W-1:0]   want;
    } probe_t;

    localparam int N_PROBES    = 22;
    localparam int ITEM_TARGET = 580;
    localparam int QUIET_FROM  = 530;
    localparam int SETTLE      = ROW_DEPTH + 80;

    localparam probe_t PROBES [0:N_PROBES-1] = '{
        '{1'b0, 10'd0,    10'd0,     16'd0,      1'b1, 1'b1, 32'd0},
        '{1'b0, 10'd0,    10'd1023,  16'd65535,  1'b1, 1'b1, 32'd65535},
        '{1'b0, 10'd0,    10'd0,     16'd65535,  1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd0,     16'd65535,  1'b1, 1'b1, 32'd131070},
        '{1'b0, 10'd0,    10'd1023,  16'd100,    1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd1023,  16'd200,    1'b1, 1'b1, 32'd200},
        '{1'b0, 10'd0,    10'h2AA,   16'h5555,   1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'h155,   16'hAAAA,   1'b1, 1'b1, 32'h0000_FFFF},
        '{1'b1, 10'd0,    10'd0,     16'd9,      1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd1,     16'd100,    1'b1, 1'b1, 32'd9},
        '{1'b0, 10'd0,    10'd1,     16'd100,    1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd0,     16'd7,      1'b1, 1'b1, 32'd7},
        '{1'b1, 10'd600,  10'd300,   16'd40,     1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd300,   16'd50,     1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd301,   16'd70,     1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd1,     16'd1,      1'b1, 1'b0, 32'd0},
        '{1'b1, 10'd1023, 10'd512,   16'd65535,  1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd511,   16'd65535,  1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd1,     16'd65535,  1'b1, 1'b0, 32'd0},
        '{1'b1, 10'd1,    10'd1,     16'd3,      1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd2,     16'd50,     1'b0, 1'b0, 32'd0},
        '{1'b0, 10'd0,    10'd0,     16'd4,      1'b1, 1'b0, 32'd0}
    };

    logic                aclk;
    logic                aresetn       = 1'b0;
    logic                cfg_wr_en     = 1'b0;
    logic [CAP_W-1:0]    cfg_wr_data   = '0;
    logic                s_valid       = 1'b0;
    logic                s_ready;
    logic [WEIGHT_W-1:0] s_item_weight = '0;
    logic [VALUE_W-1:0]  s_item_value  = '0;
    logic                s_last_item   = 1'b0;
    logic                m_valid;
    logic                m_ready       = 1'b0;
    logic [BEST_W-1:0]   m_best_value;

    logic [BEST_W-1:0] knap_row [0:MAX_CAPACITY];
    logic [CAP_W-1:0]  knap_cap;
    logic [BEST_W-1:0] want_best_q [$];
    int                item_count;
    int                mismatch_count;
    bit                quiet;
    int unsigned       stall_left;

    zero_one_knapsack_dp_top DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item_weight (s_item_weight),
        .s_item_value  (s_item_value),
        .s_last_item   (s_last_item),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_best_value  (m_best_value)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #48_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // sweep downward so each item is taken at most once; saturate the sum
    task automatic knap_update(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                               input logic last_i, output logic [BEST_W-1:0] best);
        logic [BEST_W:0] cand;
        int              wi;
        int              j;
        int              at;
        wi   = int'(w);
        best = '0;
        if (wi <= MAX_CAPACITY) begin
            for (j = MAX_CAPACITY; j >= wi; j--) begin
                cand = {1'b0, knap_row[j - wi]} + (BEST_W+1)'(v);
                if (cand[BEST_W])
                    cand = {1'b0, {BEST_W{1'b1}}};
                if (cand[BEST_W-1:0] > knap_row[j])
                    knap_row[j] = cand[BEST_W-1:0];
            end
        end
        if (last_i) begin
            at   = (int'(knap_cap) > MAX_CAPACITY) ? MAX_CAPACITY : int'(knap_cap);
            best = knap_row[at];
            for (j = 0; j <= MAX_CAPACITY; j++)
                knap_row[j] = '0;
        end
    endtask

    task automatic offer_item(input logic [WEIGHT_W-1:0] w, input logic [VALUE_W-1:0] v,
                              input logic last_i, input logic known,
                              input logic [BEST_W-1:0] want);
        logic [BEST_W-1:0] best;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_item_weight <= w;
        s_item_value  <= v;
        s_last_item   <= last_i;
        do @(posedge aclk); while (!s_ready);
        knap_update(w, v, last_i, best);
        if (last_i)
            want_best_q = {want_best_q, (known ? want : best)};
        item_count++;
    endtask

    // drain results and let the row clear finish before touching the register
    task automatic load_capacity(input logic [CAP_W-1:0] c);
        s_valid <= 1'b0;
        while (want_best_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= c;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        knap_cap = c;
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (want_best_q.size() == 0) begin
                $error("best_value: no result expected, actual %0d", m_best_value);
                mismatch_count++;
            end else begin
                if (m_best_value !== want_best_q[0]) begin
                    $error("best_value: expected %0d, actual %0d",
                           want_best_q[0], m_best_value);
                    mismatch_count++;
                end
                void'(want_best_q.pop_front());
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (quiet) begin
            m_ready <= 1'b1;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            m_ready    <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            m_ready    <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    initial begin
        int                  i;
        int                  set_len;
        int                  pick;
        logic [WEIGHT_W-1:0] w;
        logic [VALUE_W-1:0]  v;
        logic [CAP_W-1:0]    c;

        item_count     = 0;
        mismatch_count = 0;
        quiet          = 1'b0;
        stall_left     = 0;
        knap_cap       = CAP_RESET;
        for (i = 0; i <= MAX_CAPACITY; i++)
            knap_row[i] = '0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < N_PROBES; i++) begin
            if (PROBES[i].cap_wr)
                load_capacity(PROBES[i].cap);
            offer_item(PROBES[i].weight, PROBES[i].value, PROBES[i].last,
                       PROBES[i].known, PROBES[i].want);
        end

        while (item_count < ITEM_TARGET) begin
            if (item_count >= QUIET_FROM)
                quiet = 1'b1;
            if (!quiet && $urandom_range(0, 7) == 0) begin
                pick = $urandom_range(0, 3);
                if (pick == 0)
                    c = '0;
                else if (pick == 1)
                    c = CAP_W'(MAX_CAPACITY);
                else
                    c = CAP_W'($urandom_range(0, MAX_CAPACITY));
                load_capacity(c);
            end
            set_len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12)
                                                  : $urandom_range(1, 6);
            for (i = 0; i < set_len; i++) begin
                pick = $urandom_range(0, 9);
                if (pick <= 3)
                    w = WEIGHT_W'($urandom_range(0, 40));
                else if (pick <= 6)
                    w = WEIGHT_W'($urandom_range(0, 1023));
                else if (pick == 7)
                    w = '0;
                else if (pick == 8)
                    w = '1;
                else
                    w = WEIGHT_W'($urandom_range(900, 1023));
                pick = $urandom_range(0, 7);
                if (pick == 0)
                    v = '0;
                else if (pick == 1)
                    v = '1;
                else
                    v = VALUE_W'($urandom_range(0, 65535));
                offer_item(w, v, i == set_len - 1, 1'b0, '0);
            end
        end

        s_valid <= 1'b0;
        quiet = 1'b1;
        while (want_best_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule

### filelist.f
rtl/knap_pkg.sv
rtl/knap_front.sv
rtl/knap_queue.sv
rtl/knap_back.sv
rtl/zero_one_knapsack_dp_top.sv
rtl/knap_checker.sv
tb/tb.sv
